@@ rtl/sgif_pkg.sv @@
package sgif_pkg;

  // stream widths
  localparam int unsigned InW  = 160;
  localparam int unsigned OutW = 96;

  // cordic datapath, Q2.30 with headroom
  localparam int unsigned CordicIters = 30;
  localparam int unsigned CordicW     = 34;

  localparam logic signed [CordicW-1:0] GainInv = 34'sd652032874;
  localparam logic signed [CordicW-1:0] HalfPi  = 34'sd1686629713;
  localparam logic signed [CordicW-1:0] Q30One  = 34'sd1073741824;
  localparam logic [31:0]               PiQ30   = 32'd3373259426;

  localparam logic [29:0] AtanTab [CordicIters] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
    30'd32,        30'd16,        30'd8,         30'd4,         30'd2
  };

  // divider: 63-bit magnitude by 31-bit divisor, 32 quotient bits
  localparam int unsigned DivNW = 63;
  localparam int unsigned DivDW = 31;
  localparam int unsigned DivQW = 32;

  localparam logic signed [63:0] S32Max = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32Min = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic              sat;
    logic signed [31:0] val;
  } sat32_t;

  function automatic sat32_t clamp32(input logic signed [63:0] v);
    sat32_t res;
    if (v > S32Max) begin
      res.sat = 1'b1;
      res.val = S32Max[31:0];
    end else if (v < S32Min) begin
      res.sat = 1'b1;
      res.val = S32Min[31:0];
    end else begin
      res.sat = 1'b0;
      res.val = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [63:0] sx(input logic signed [31:0] a);
    return {{32{a[31]}}, a};
  endfunction

endpackage

@@ rtl/sgif_div.sv @@
module sgif_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       neg_i,
  input  logic [sgif_pkg::DivNW-1:0] num_i,
  input  logic [sgif_pkg::DivDW-1:0] den_i,
  output logic [sgif_pkg::DivQW-1:0] quo_o,
  output logic                       ovf_o,
  output logic                       neg_o
);
  import sgif_pkg::*;

  logic [DivNW-1:0] rem_q [DivQW];
  logic [DivQW-1:0] quo_q [DivQW];
  logic [DivDW-1:0] den_q [DivQW];
  logic             ovf_q [DivQW];
  logic             neg_q [DivQW];

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < DivQW; k++) begin : g_stage
    logic [DivNW-1:0] rem_in;
    logic [DivQW-1:0] quo_in;
    logic [DivDW-1:0] den_in;
    logic             ovf_in;
    logic             neg_in;
    logic [DivNW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      // quotient would need more than 32 bits
      assign ovf_in = (num_i[DivNW-1:DivQW] >= den_i);
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign ovf_in = ovf_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign diff = {1'b0, rem_in} - ({{(DivNW+1-DivDW){1'b0}}, den_in} << (DivQW-1-k));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= diff[DivNW] ? rem_in : diff[DivNW-1:0];
        quo_q[k] <= diff[DivNW] ? quo_in
                                : (quo_in | ({{(DivQW-1){1'b0}}, 1'b1} << (DivQW-1-k)));
        den_q[k] <= den_in;
        ovf_q[k] <= ovf_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  assign quo_o = quo_q[DivQW-1];
  assign ovf_o = ovf_q[DivQW-1];
  assign neg_o = neg_q[DivQW-1];

endmodule

@@ rtl/spherical_geodesic_inertial_force.sv @@
// channel  dir  tdata (lsb first)                                    tuser
// s_axis   in   radius 31, polar_angle 32, radial_rate 32,           -
//               polar_rate 32, azimuthal_rate 32, pad 1
// m_axis   out  radial_accel 32, polar_accel 32, azimuthal_accel 32  saturated
//
// one transfer per cycle in and out unless the output stalls; data passes the input
// register, 30-step cordic pipeline, 32-stage division pipeline, multiply chain.
// reset clears only the valid bits; the data path has no reset.
// when the output register is full and not taken the whole pipeline holds.
module spherical_geodesic_inertial_force (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // radius, polar_angle, radial_rate, polar_rate, azimuthal_rate, zero pad
  input  logic [sgif_pkg::InW-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // radial_accel, polar_accel, azimuthal_accel
  output logic [sgif_pkg::OutW-1:0]     m_axis_tdata,
  // saturated
  output logic [0:0]                    m_axis_tuser
);
  import sgif_pkg::*;

  localparam int unsigned NumStg = 72;
  localparam int unsigned OutStg = NumStg - 1;

  typedef struct packed {
    logic [30:0]        r;
    logic signed [31:0] vr;
    logic signed [31:0] vth;
    logic signed [31:0] vph;
    logic signed [63:0] pq;
    logic signed [63:0] pvt;
    logic signed [63:0] pvp;
  } cor_carry_t;

  typedef struct packed {
    logic [30:0]        r;
    logic signed [31:0] vth;
    logic signed [31:0] vph;
    logic signed [31:0] vth2;
    logic signed [31:0] vph2;
    logic [30:0]        s;
    logic signed [31:0] c;
    logic               sat;
  } div_carry_t;

  logic [NumStg-1:0] vld_q;
  logic              adv;

  assign adv           = !vld_q[OutStg] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[OutStg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStg-2:0], s_axis_tvalid};
    end
  end

  // input register
  logic [30:0]        in_r_q;
  logic [31:0]        in_th_q;
  logic signed [31:0] in_vr_q, in_vth_q, in_vph_q;
  logic [30:0]        r_raw;
  logic [31:0]        th_raw;

  assign r_raw  = s_axis_tdata[30:0];
  assign th_raw = s_axis_tdata[62:31];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_r_q   <= (r_raw == '0) ? 31'd1 : r_raw;
      in_th_q  <= (th_raw > PiQ30) ? PiQ30 : th_raw;
      in_vr_q  <= s_axis_tdata[94:63];
      in_vth_q <= s_axis_tdata[126:95];
      in_vph_q <= s_axis_tdata[158:127];
    end
  end

  // products and cordic start
  logic signed [CordicW-1:0] cx_q [CordicIters+1];
  logic signed [CordicW-1:0] cy_q [CordicIters+1];
  logic signed [CordicW-1:0] cz_q [CordicIters+1];
  cor_carry_t                cc_q [CordicIters+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0]     <= GainInv;
      cy_q[0]     <= '0;
      cz_q[0]     <= $signed({2'b00, in_th_q}) - HalfPi;
      cc_q[0].r   <= in_r_q;
      cc_q[0].vr  <= in_vr_q;
      cc_q[0].vth <= in_vth_q;
      cc_q[0].vph <= in_vph_q;
      cc_q[0].pq  <= in_vr_q * in_vth_q;
      cc_q[0].pvt <= in_vth_q * in_vth_q;
      cc_q[0].pvp <= in_vph_q * in_vph_q;
    end
  end

  for (genvar i = 0; i < CordicIters; i++) begin : g_cordic
    logic signed [CordicW-1:0] xs, ys, atn;
    assign xs  = cx_q[i] >>> i;
    assign ys  = cy_q[i] >>> i;
    assign atn = $signed({{(CordicW-30){1'b0}}, AtanTab[i]});

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!cz_q[i][CordicW-1]) begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          cz_q[i+1] <= cz_q[i] - atn;
        end else begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          cz_q[i+1] <= cz_q[i] + atn;
        end
        cc_q[i+1] <= cc_q[i];
      end
    end
  end

  // sine, cosine, squares and divider operands
  cor_carry_t                cend;
  logic signed [CordicW-1:0] cx_end, ny;
  logic [30:0]               sin_v;
  logic signed [31:0]        cos_v;
  logic [31:0]               cos_mag;
  sat32_t                    vth2_s, vph2_s;
  logic signed [63:0]        pq_mag;
  logic [32:0]               vr_ext, vr_mag;

  assign cend   = cc_q[CordicIters];
  assign cx_end = cx_q[CordicIters];
  assign ny     = -cy_q[CordicIters];

  always_comb begin
    if (cx_end < 0) begin
      sin_v = '0;
    end else if (cx_end > Q30One) begin
      sin_v = Q30One[30:0];
    end else begin
      sin_v = cx_end[30:0];
    end
    if (ny > Q30One) begin
      cos_v = Q30One[31:0];
    end else if (ny < -Q30One) begin
      cos_v = -Q30One[31:0];
    end else begin
      cos_v = ny[31:0];
    end
  end

  assign cos_mag = cos_v[31] ? (32'd0 - cos_v) : cos_v;
  assign vth2_s  = clamp32(cend.pvt >>> 16);
  assign vph2_s  = clamp32(cend.pvp >>> 16);
  assign pq_mag  = cend.pq[63] ? (64'sd0 - cend.pq) : cend.pq;
  assign vr_ext  = {cend.vr[31], cend.vr};
  assign vr_mag  = cend.vr[31] ? (33'd0 - vr_ext) : vr_ext;

  div_carry_t       dc_q [DivQW+1];
  logic             dq_neg_q, dr_neg_q, dc_neg_q;
  logic [DivNW-1:0] dq_num_q, dr_num_q, dc_num_q;
  logic [DivDW-1:0] dq_den_q, dc_den_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dc_q[0].r    <= cend.r;
      dc_q[0].vth  <= cend.vth;
      dc_q[0].vph  <= cend.vph;
      dc_q[0].vth2 <= vth2_s.val;
      dc_q[0].vph2 <= vph2_s.val;
      dc_q[0].s    <= sin_v;
      dc_q[0].c    <= cos_v;
      dc_q[0].sat  <= vth2_s.sat | vph2_s.sat;
      dq_neg_q     <= cend.pq[63];
      dq_num_q     <= pq_mag[DivNW-1:0];
      dq_den_q     <= cend.r;
      dr_neg_q     <= cend.vr[31];
      dr_num_q     <= {15'd0, vr_mag[31:0], 16'd0};
      dc_neg_q     <= cos_v[31];
      dc_num_q     <= {16'd0, cos_mag[30:0], 16'd0};
      dc_den_q     <= sin_v;
    end
  end

  logic [DivQW-1:0] q_quo, r_quo, c_quo;
  logic             q_ovf, r_ovf, c_ovf, q_neg, r_neg, c_neg;

  sgif_div u_div_q (
    .clk_i, .en_i(adv), .neg_i(dq_neg_q), .num_i(dq_num_q), .den_i(dq_den_q),
    .quo_o(q_quo), .ovf_o(q_ovf), .neg_o(q_neg)
  );

  sgif_div u_div_ratio (
    .clk_i, .en_i(adv), .neg_i(dr_neg_q), .num_i(dr_num_q), .den_i(dq_den_q),
    .quo_o(r_quo), .ovf_o(r_ovf), .neg_o(r_neg)
  );

  sgif_div u_div_cot (
    .clk_i, .en_i(adv), .neg_i(dc_neg_q), .num_i(dc_num_q), .den_i(dc_den_q),
    .quo_o(c_quo), .ovf_o(c_ovf), .neg_o(c_neg)
  );

  for (genvar k = 0; k < DivQW; k++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dc_q[k+1] <= dc_q[k];
      end
    end
  end

  // signed quotient from magnitude, truncated toward zero
  function automatic sat32_t div_fix(input logic neg, input logic [31:0] quo,
                                     input logic ovf);
    sat32_t res;
    if (neg) begin
      if (ovf || quo > 32'h8000_0000) begin
        res.sat = 1'b1;
        res.val = S32Min[31:0];
      end else begin
        res.sat = 1'b0;
        res.val = 32'd0 - quo;
      end
    end else begin
      if (ovf || quo[31]) begin
        res.sat = 1'b1;
        res.val = S32Max[31:0];
      end else begin
        res.sat = 1'b0;
        res.val = quo;
      end
    end
    return res;
  endfunction

  div_carry_t dend;
  sat32_t     q_s, ratio_s, cot_s;

  assign dend    = dc_q[DivQW];
  assign q_s     = div_fix(q_neg, q_quo, q_ovf);
  assign ratio_s = div_fix(r_neg, r_quo, r_ovf);

  always_comb begin
    if (dend.s == '0) begin
      // pole: cotangent pinned to the extreme of cos sign
      cot_s.sat = 1'b1;
      cot_s.val = dend.c[31] ? S32Min[31:0] : S32Max[31:0];
    end else begin
      cot_s = div_fix(c_neg, c_quo, c_ovf);
    end
  end

  // e0: quotients final
  logic [30:0]        e0_r_q, e0_s_q;
  logic signed [31:0] e0_vth_q, e0_vph_q, e0_vth2_q, e0_vph2_q, e0_c_q;
  logic signed [31:0] e0_q_q, e0_ratio_q, e0_cot_q;
  logic               e0_sat_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e0_r_q     <= dend.r;
      e0_s_q     <= dend.s;
      e0_vth_q   <= dend.vth;
      e0_vph_q   <= dend.vph;
      e0_vth2_q  <= dend.vth2;
      e0_vph2_q  <= dend.vph2;
      e0_c_q     <= dend.c;
      e0_q_q     <= q_s.val;
      e0_ratio_q <= ratio_s.val;
      e0_cot_q   <= cot_s.val;
      e0_sat_q   <= dend.sat | q_s.sat | ratio_s.sat | cot_s.sat;
    end
  end

  // e1: first products
  sat32_t             q2_s;
  logic signed [63:0] e1_pw1_q, e1_psc_q, e1_pt1_q, e1_pcot_q;
  logic [30:0]        e1_r_q, e1_s_q;
  logic signed [31:0] e1_vph_q, e1_vph2_q, e1_ratio_q, e1_q2_q;
  logic               e1_sat_q;

  assign q2_s = clamp32(sx(e0_q_q) + sx(e0_q_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_pw1_q   <= e0_vph2_q * $signed({1'b0, e0_s_q});
      e1_psc_q   <= $signed({1'b0, e0_s_q}) * e0_c_q;
      e1_pt1_q   <= $signed({1'b0, e0_r_q}) * e0_vth2_q;
      e1_pcot_q  <= e0_cot_q * e0_vth_q;
      e1_r_q     <= e0_r_q;
      e1_s_q     <= e0_s_q;
      e1_vph_q   <= e0_vph_q;
      e1_vph2_q  <= e0_vph2_q;
      e1_ratio_q <= e0_ratio_q;
      e1_q2_q    <= q2_s.val;
      e1_sat_q   <= e0_sat_q | q2_s.sat;
    end
  end

  // e2: scale and first sums
  sat32_t             w1_s, t1_s, tc_s, a1_s;
  logic signed [63:0] psc_sh;
  logic signed [31:0] e2_w1_q, e2_sc_q, e2_t1_q, e2_a1_q, e2_vph_q, e2_vph2_q, e2_q2_q;
  logic [30:0]        e2_r_q, e2_s_q;
  logic               e2_sat_q;

  assign w1_s   = clamp32(e1_pw1_q >>> 30);
  assign psc_sh = e1_psc_q >>> 30;
  assign t1_s   = clamp32(e1_pt1_q >>> 16);
  assign tc_s   = clamp32(e1_pcot_q >>> 16);
  assign a1_s   = clamp32(sx(e1_ratio_q) + sx(tc_s.val));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e2_w1_q   <= w1_s.val;
      e2_sc_q   <= psc_sh[31:0];
      e2_t1_q   <= t1_s.val;
      e2_a1_q   <= a1_s.val;
      e2_vph_q  <= e1_vph_q;
      e2_vph2_q <= e1_vph2_q;
      e2_q2_q   <= e1_q2_q;
      e2_r_q    <= e1_r_q;
      e2_s_q    <= e1_s_q;
      e2_sat_q  <= e1_sat_q | w1_s.sat | t1_s.sat | tc_s.sat | a1_s.sat;
    end
  end

  // e3: second products
  logic signed [63:0] e3_pw_q, e3_pp1_q, e3_pa2_q;
  logic signed [31:0] e3_t1_q, e3_q2_q;
  logic [30:0]        e3_r_q;
  logic               e3_sat_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e3_pw_q  <= e2_w1_q * $signed({1'b0, e2_s_q});
      e3_pp1_q <= e2_vph2_q * e2_sc_q;
      e3_pa2_q <= e2_a1_q * e2_vph_q;
      e3_t1_q  <= e2_t1_q;
      e3_q2_q  <= e2_q2_q;
      e3_r_q   <= e2_r_q;
      e3_sat_q <= e2_sat_q;
    end
  end

  // e4: polar result
  sat32_t             w_s, p1_s, pol_s, a2_s;
  logic signed [31:0] e4_w_q, e4_pol_q, e4_a2_q, e4_t1_q;
  logic [30:0]        e4_r_q;
  logic               e4_sat_q;

  assign w_s   = clamp32(e3_pw_q >>> 30);
  assign p1_s  = clamp32(e3_pp1_q >>> 30);
  assign pol_s = clamp32(sx(p1_s.val) - sx(e3_q2_q));
  assign a2_s  = clamp32(e3_pa2_q >>> 16);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e4_w_q   <= w_s.val;
      e4_pol_q <= pol_s.val;
      e4_a2_q  <= a2_s.val;
      e4_t1_q  <= e3_t1_q;
      e4_r_q   <= e3_r_q;
      e4_sat_q <= e3_sat_q | w_s.sat | p1_s.sat | pol_s.sat | a2_s.sat;
    end
  end

  // e5: azimuthal result, last radial product
  sat32_t             az_s;
  logic signed [63:0] e5_pt2_q;
  logic signed [31:0] e5_az_q, e5_pol_q, e5_t1_q;
  logic               e5_sat_q;

  assign az_s = clamp32(64'sd0 - (sx(e4_a2_q) + sx(e4_a2_q)));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e5_pt2_q <= $signed({1'b0, e4_r_q}) * e4_w_q;
      e5_az_q  <= az_s.val;
      e5_pol_q <= e4_pol_q;
      e5_t1_q  <= e4_t1_q;
      e5_sat_q <= e4_sat_q | az_s.sat;
    end
  end

  // output register
  sat32_t             t2_s, rad_s;
  logic signed [31:0] out_rad_q, out_pol_q, out_az_q;
  logic               out_sat_q;

  assign t2_s  = clamp32(e5_pt2_q >>> 16);
  assign rad_s = clamp32(sx(e5_t1_q) + sx(t2_s.val));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rad_q <= rad_s.val;
      out_pol_q <= e5_pol_q;
      out_az_q  <= e5_az_q;
      out_sat_q <= e5_sat_q | t2_s.sat | rad_s.sat;
    end
  end

  assign m_axis_tdata = {out_az_q, out_pol_q, out_rad_q};
  assign m_axis_tuser = out_sat_q;

endmodule

@@ tb/spherical_geodesic_inertial_force_tb.sv @@
`timescale 1ns / 100ps

module spherical_geodesic_inertial_force_tb;
  import sgif_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Latency    = 72;
  localparam longint      S32Hi      = 64'sd2147483647;
  localparam longint      S32Lo      = -64'sd2147483648;

  typedef struct packed {
    logic [30:0]        radius;
    logic [31:0]        polar_angle;
    logic signed [31:0] radial_rate;
    logic signed [31:0] polar_rate;
    logic signed [31:0] azimuthal_rate;
  } particle_t;

  typedef struct packed {
    logic signed [31:0] radial_accel;
    logic signed [31:0] polar_accel;
    logic signed [31:0] azimuthal_accel;
    logic               saturated;
  } accel_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [InW-1:0]     s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [OutW-1:0]    m_axis_tdata;
  logic [0:0]         m_axis_tuser;

  accel_t      accel_q[$];
  int unsigned errors;
  int unsigned cycles;
  bit          steady;

  spherical_geodesic_inertial_force DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sat32(input longint v, inout bit flag);
    if (v > S32Hi) begin
      flag = 1'b1;
      return S32Hi;
    end
    if (v < S32Lo) begin
      flag = 1'b1;
      return S32Lo;
    end
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b, input int sh,
                                  inout bit flag);
    return sat32((a * b) >>> sh, flag);
  endfunction

  function automatic accel_t geodesic_accel(input particle_t p);
    accel_t res;
    bit     f;
    longint r, th, vr, vth, vph, x, y, z, xs, ys, s, c;
    longint vth2, vph2, w, sc, q, ratio, cot, az, ta, tb;
    f   = 1'b0;
    r   = longint'(p.radius);
    th  = longint'(p.polar_angle);
    vr  = longint'(p.radial_rate);
    vth = longint'(p.polar_rate);
    vph = longint'(p.azimuthal_rate);
    if (r == 0) r = 1;
    if (th > longint'(PiQ30)) th = longint'(PiQ30);
    x = longint'(GainInv);
    y = 0;
    z = th - longint'(HalfPi);
    for (int i = 0; i < CordicIters; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(AtanTab[i]);
      end else begin
        x += ys; y -= xs; z += longint'(AtanTab[i]);
      end
    end
    s = (x < 0) ? 0 : (x > longint'(Q30One)) ? longint'(Q30One) : x;
    c = -y;
    if (c < -longint'(Q30One)) c = -longint'(Q30One);
    if (c > longint'(Q30One)) c = longint'(Q30One);

    vth2 = qmul(vth, vth, 16, f);
    vph2 = qmul(vph, vph, 16, f);
    ta   = qmul(vph2, s, 30, f);
    w    = qmul(ta, s, 30, f);
    ta   = qmul(r, vth2, 16, f);
    tb   = qmul(r, w, 16, f);
    res.radial_accel = 32'(sat32(ta + tb, f));

    sc = (s * c) >>> 30;
    q  = sat32((vr * vth) / r, f);
    q  = sat32(2 * q, f);
    ta = qmul(vph2, sc, 30, f);
    res.polar_accel = 32'(sat32(ta - q, f));

    ratio = sat32((vr * 65536) / r, f);
    // pole: cotangent pinned to the extreme of cos's sign
    if (s == 0) begin
      f   = 1'b1;
      cot = (c >= 0) ? S32Hi : S32Lo;
    end else begin
      cot = sat32((c * 65536) / s, f);
    end
    ta = qmul(cot, vth, 16, f);
    az = sat32(ratio + ta, f);
    az = qmul(az, vph, 16, f);
    res.azimuthal_accel = 32'(sat32(-2 * az, f));
    res.saturated = f;
    return res;
  endfunction

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 30);
  endfunction

  task automatic send_particle(input particle_t p);
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, p.azimuthal_rate, p.polar_rate, p.radial_rate,
                      p.polar_angle, p.radius};
    do @(posedge clk_i); while (!s_axis_tready);
    accel_q.push_back(geodesic_accel(p));
  endtask

  function automatic logic signed [31:0] rand_rate();
    // spread magnitudes so that results often stay unclamped
    return $signed($urandom) >>> $urandom_range(31, 0);
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    p.radius = (|$urandom_range(3)) ? 31'($urandom) >> $urandom_range(30, 0)
                                    : 31'($urandom);
    p.polar_angle = (|$urandom_range(7)) ? 32'($urandom_range(PiQ30 - 1, 1))
                                         : 32'($urandom);
    p.radial_rate    = rand_rate();
    p.polar_rate     = rand_rate();
    p.azimuthal_rate = rand_rate();
    return p;
  endfunction

  task automatic test_extremes();
    logic [31:0]        angles [6];
    logic signed [31:0] rates  [4];
    logic [30:0]        radii  [3];
    particle_t          p;
    angles = '{32'd0, 32'd1, HalfPi[31:0], PiQ30 - 32'd1, PiQ30, 32'hFFFF_FFFF};
    rates  = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1};
    radii  = '{31'd0, 31'd1, 31'h7FFF_FFFF};
    for (int i = 0; i < 6; i++) begin
      p = '{31'd65536, angles[i], 32'sd65536, 32'sd65536, 32'sd65536};
      send_particle(p);
    end
    for (int i = 0; i < 12; i++) begin
      p = '{radii[i % 3], angles[(i + 2) % 6], rates[i % 4], rates[(i + 1) % 4],
            rates[(i + 3) % 4]};
      send_particle(p);
    end
    send_particle('{31'd65536, HalfPi[31:0] / 2, 32'sd131072, -32'sd65536,
                    32'sd32768});
  endtask

  task automatic test_random();
    for (int i = 0; i < 700; i++) begin
      steady = (i >= 300 && i < 400);
      send_particle(rand_particle());
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= !idle_now();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("spherical_geodesic_inertial_force_tb failed");
      $finish;
    end
  end

  // compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    accel_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tuser[0]};
      if (accel_q.size() == 0) begin
        $error("unexpected transfer: radial_accel %0d", got.radial_accel);
        errors++;
      end else begin
        want = accel_q.pop_front();
        if (got.radial_accel !== want.radial_accel) begin
          $error("radial_accel expected %0d got %0d", want.radial_accel,
                 got.radial_accel);
          errors++;
        end
        if (got.polar_accel !== want.polar_accel) begin
          $error("polar_accel expected %0d got %0d", want.polar_accel,
                 got.polar_accel);
          errors++;
        end
        if (got.azimuthal_accel !== want.azimuthal_accel) begin
          $error("azimuthal_accel expected %0d got %0d", want.azimuthal_accel,
                 got.azimuthal_accel);
          errors++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated expected %0b got %0b", want.saturated, got.saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    errors        = 0;
    cycles        = 0;
    steady        = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random();
    while (accel_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (errors == 0 && accel_q.size() == 0) begin
      $display("spherical_geodesic_inertial_force_tb passed");
    end else begin
      $display("spherical_geodesic_inertial_force_tb failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sgif_pkg.sv
rtl/sgif_div.sv
rtl/spherical_geodesic_inertial_force.sv
tb/spherical_geodesic_inertial_force_tb.sv
